FILE: sv/log_page_parameter_extract_unit_macros.svh
// ---------------------------------------------------------------------------
// Log page parameter extract: assertion macros
// Shared concurrent assertion forms used by the RTL of this block.
// ---------------------------------------------------------------------------
`ifndef LOG_PAGE_PARAMETER_EXTRACT_UNIT_MACROS_SVH
`define LOG_PAGE_PARAMETER_EXTRACT_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lppe_pkg.sv
// ---------------------------------------------------------------------------
// Log page parameter extract: package
// Parse phase encoding, result word type and fixed field widths.
// ---------------------------------------------------------------------------
package lppe_pkg;

   localparam int unsigned ByteW   = 8;
   localparam int unsigned CodeW   = 16;
   localparam int unsigned ValueW  = 64;
   localparam int unsigned PosW    = 17;
   localparam int unsigned PageHdrLast = 3;   // last byte of the page header
   localparam int unsigned PageHdrLen  = 4;   // parameters start here
   localparam int unsigned ParamHdrLast = 3;  // length byte of a param header

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PAGE_HDR,
      PH_PARAM_HDR,
      PH_SKIP,
      PH_GATHER
   } lppe_phase_type;

   typedef struct packed {
      logic              found;
      logic [ValueW-1:0] param_value;
      logic [ByteW-1:0]  param_length;
   } lppe_result_type;

endpackage

FILE: sv/lppe_parser.sv
// ---------------------------------------------------------------------------
// Log page parameter extract: byte parser
// Per-byte parse state and the result of the byte being consumed.
// ---------------------------------------------------------------------------
`include "log_page_parameter_extract_unit_macros.svh"

module lppe_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [lppe_pkg::ByteW-1:0]    page_byte,
   input  logic                          page_start,
   input  logic [lppe_pkg::CodeW-1:0]    wanted_code,
   output logic                          res_valid,
   output lppe_pkg::lppe_result_type     res
);
   import lppe_pkg::*;

   lppe_phase_type     phase_ff, phase_in, phase_cur;
   logic [PosW-1:0]    pos_ff, pos_in, pos_cur, pos_next, page_end;
   logic [CodeW-1:0]   len_ff, len_in, len_cur, len_upd;
   logic [CodeW-1:0]   code_ff, code_in, code_cur;
   logic [ByteW-1:0]   left_ff, left_in, left_cur, left_dec;
   logic [ValueW-1:0]  val_ff, val_in, val_cur, val_new;
   logic [ByteW-1:0]   mlen_ff, mlen_in, mlen_cur;
   logic               hdr_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         code_ff  <= '0;
         left_ff  <= '0;
         val_ff   <= '0;
         mlen_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         code_ff  <= code_in;
         left_ff  <= left_in;
         val_ff   <= val_in;
         mlen_ff  <= mlen_in;
      end
   end

   always_comb begin
      // a start byte wipes the page state before it is parsed
      phase_cur = page_start ? PH_PAGE_HDR : phase_ff;
      pos_cur   = page_start ? '0 : pos_ff;
      len_cur   = page_start ? '0 : len_ff;
      code_cur  = page_start ? '0 : code_ff;
      left_cur  = page_start ? '0 : left_ff;
      val_cur   = page_start ? '0 : val_ff;
      mlen_cur  = page_start ? '0 : mlen_ff;

      len_upd = len_cur;
      if (phase_cur == PH_PAGE_HDR) begin
         if (pos_cur == PosW'(2)) begin
            len_upd = {page_byte, len_cur[7:0]};
         end else if (pos_cur == PosW'(PageHdrLast)) begin
            len_upd = {len_cur[15:8], page_byte};
         end
      end
      pos_next = pos_cur + PosW'(1);
      page_end = {1'b0, len_upd} + PosW'(PageHdrLen);
      hdr_end  = (pos_next >= page_end);
      left_dec = left_cur - ByteW'(1);
      val_new  = {val_cur[ValueW-ByteW-1:0], page_byte};

      phase_in  = phase_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      code_in   = code_ff;
      left_in   = left_ff;
      val_in    = val_ff;
      mlen_in   = mlen_ff;
      res_valid = 1'b0;
      res       = '0;

      if (fire) begin
         phase_in = phase_cur;
         pos_in   = pos_cur;
         len_in   = len_cur;
         code_in  = code_cur;
         left_in  = left_cur;
         val_in   = val_cur;
         mlen_in  = mlen_cur;
         if (phase_cur != PH_IDLE) begin
            pos_in = pos_next;
            len_in = len_upd;
            unique case (phase_cur)
               PH_PAGE_HDR: begin
                  if (pos_cur >= PosW'(PageHdrLast)) begin
                     if (hdr_end) begin
                        res_valid = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_PARAM_HDR;
                        left_in  = '0;
                     end
                  end
               end
               PH_PARAM_HDR: begin
                  if (left_cur == ByteW'(0)) begin
                     code_in = {page_byte, code_cur[7:0]};
                  end else if (left_cur == ByteW'(1)) begin
                     code_in = {code_cur[15:8], page_byte};
                  end
                  if (left_cur < ByteW'(ParamHdrLast)) begin
                     left_in = left_cur + ByteW'(1);
                  end else if (code_cur == wanted_code) begin
                     mlen_in = page_byte;
                     val_in  = '0;
                     if (page_byte == '0) begin
                        res_valid = 1'b1;
                        res.found = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        left_in  = page_byte;
                        phase_in = PH_GATHER;
                     end
                  end else if (page_byte == '0) begin
                     if (hdr_end) begin
                        res_valid = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_PARAM_HDR;
                        left_in  = '0;
                     end
                  end else begin
                     left_in  = page_byte;
                     phase_in = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     if (hdr_end) begin
                        res_valid = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        phase_in = PH_PARAM_HDR;
                        left_in  = '0;
                     end
                  end
               end
               PH_GATHER: begin
                  val_in  = val_new;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     res_valid        = 1'b1;
                     res.found        = 1'b1;
                     res.param_value  = val_new;
                     res.param_length = mlen_cur;
                     phase_in         = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   `LPPE_ASSERT_NEXT(a_idle_after_result, clock, reset, fire && res_valid, phase_ff == PH_IDLE, "parser not idle after result")
   `LPPE_ASSERT_NOW(a_miss_is_zero, clock, reset, res_valid && !res.found, res.param_value == '0 && res.param_length == '0, "not-found result carries data")
   `LPPE_ASSERT_NOW(a_count_live, clock, reset, phase_ff == PH_GATHER || phase_ff == PH_SKIP, left_ff != '0, "value byte count empty in value phase")

endmodule

FILE: sv/log_page_parameter_extract_unit.sv
// ---------------------------------------------------------------------------
// Log page parameter extract unit
// Scans a log page byte stream for one parameter code and returns its value.
// ---------------------------------------------------------------------------
// Feed the page one byte per word on req_, with req_page_start high on byte 0.
// Bytes 2..3 give the page length; parameter headers (code, control, length)
// follow from byte 4. When a header code equals the value last written on the
// csr_ port, its value bytes are collected big-endian (low 64 bits kept) and
// one word with rsp_found = 1 comes out; if the page runs out first, one word
// with rsp_found = 0 and zero data comes out. One rsp_ word per page at most;
// a new start byte abandons any unfinished page. The unit takes one byte per
// cycle while rsp_ is not stalled: a byte goes into an input register, the
// parser updates its state from that register and loads the result register,
// which drives rsp_. The result register decouples the two sides;
// req_stall rises only when a byte waits in the input register while a
// finished word sits stalled on rsp_. Write csr_ only while the unit is idle.
// ---------------------------------------------------------------------------
`include "log_page_parameter_extract_unit_macros.svh"

module log_page_parameter_extract_unit (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_write_en,
   input  logic [lppe_pkg::CodeW-1:0]    csr_write_data,
   // byte input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lppe_pkg::ByteW-1:0]    req_page_byte,
   input  logic                          req_page_start,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [lppe_pkg::ValueW-1:0]   rsp_param_value,
   output logic [lppe_pkg::ByteW-1:0]    rsp_param_length
);
   import lppe_pkg::*;

   logic [CodeW-1:0]  wanted_ff;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [ByteW-1:0]  in_byte_ff;
   logic              in_start_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   lppe_result_type   out_ff;

   logic              out_free;   // result register can take a new word
   logic              fire;       // parser consumes the byte in the input register
   logic              req_take;
   logic              res_valid;
   lppe_result_type   res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (in_valid_ff && !fire);
   assign out_valid_in = (fire && res_valid) ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff    <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            wanted_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_page_byte;
         in_start_ff <= req_page_start;
      end
      if (fire && res_valid) begin
         out_ff <= res;
      end
   end

   lppe_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .page_byte   (in_byte_ff),
      .page_start  (in_start_ff),
      .wanted_code (wanted_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_ff.found;
   assign rsp_param_value  = out_ff.param_value;
   assign rsp_param_length = out_ff.param_length;

   `LPPE_ASSERT_NEXT(a_hold_pending_byte, clock, reset, in_valid_ff && out_valid_ff && rsp_stall, in_valid_ff, "pending byte lost under stall")
   `LPPE_ASSERT_NEXT(a_result_loaded, clock, reset, fire && res_valid, out_valid_ff, "parser result not registered")
   `LPPE_ASSERT_NEXT(a_no_repeat, clock, reset, out_valid_ff && !rsp_stall && !(fire && res_valid), !out_valid_ff, "result word repeated")

endmodule
